@@ hw/rtl/kftc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the keyed FNV-1a tag checker.
package kftc_pkg;

	localparam int HASH_W     = 32;
	localparam int BYTE_W     = 8;
	localparam int TAG_W      = 16;
	localparam int DIGIT_W    = 4;
	localparam int DIGITS     = HASH_W / DIGIT_W;
	localparam int DCNT_W     = $clog2(DIGITS);
	localparam int KEY_BYTES  = HASH_W / BYTE_W;
	localparam int KCNT_W     = $clog2(KEY_BYTES);
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 24;
	localparam int MAX_BODY_BYTES_DEF = 32;

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C9DC5;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'h01000193;
	localparam logic [HASH_W-1:0] KEY_RESET = 32'h4D423236;

	typedef struct packed {
		logic              start;
		logic              clear;
		logic [BYTE_W-1:0] din;
	} kftc_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} kftc_sts_t;

endpackage

@@ hw/rtl/kftc_hash_unit.sv @@
`timescale 1ns / 1ps
// Running FNV-1a hash with a digit-serial multiply by the FNV prime.
module kftc_hash_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kftc_pkg::kftc_cmd_t           cmd,
	output kftc_pkg::kftc_sts_t           sts,
	output logic [kftc_pkg::HASH_W-1:0]   hash
);
	import kftc_pkg::*;

	logic [HASH_W-1:0]  hash_q;
	logic [HASH_W-1:0]  x_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic               busy_q;
	logic [DIGIT_W-1:0] nib;
	logic [HASH_W-1:0]  part;
	logic [HASH_W-1:0]  acc_next;
	logic               done;

	// Horner over the multiplicand, top digit first: acc = acc*16 + digit*prime
	assign nib      = x_q[HASH_W-1 -: DIGIT_W];
	assign part     = {{(HASH_W-DIGIT_W){1'b0}}, nib} * FNV_PRIME;
	assign acc_next = {hash_q[HASH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + part;
	assign done     = busy_q && (dcnt_q == DCNT_W'(DIGITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
			busy_q <= 1'b0;
			dcnt_q <= '0;
		end else if (busy_q) begin
			hash_q <= acc_next;
			dcnt_q <= dcnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end else if (cmd.start) begin
			hash_q <= '0;
			busy_q <= 1'b1;
			dcnt_q <= '0;
		end else if (cmd.clear) begin
			hash_q <= FNV_BASIS;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			x_q <= {x_q[HASH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end else if (cmd.start) begin
			x_q <= hash_q ^ {{(HASH_W-BYTE_W){1'b0}}, cmd.din};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done;
	assign hash     = hash_q;

endmodule

@@ hw/rtl/keyed_fnv1a_tag_checker.sv @@
`timescale 1ns / 1ps
// Top level: keyed FNV-1a tag checker with stream ports and key register.
// A body byte is accepted only in idle; after the accept cycle, eight 4-bit
// multiply digit steps run before the next byte can be accepted.
// A last byte then hashes the four key bytes the same way, plus a finish step
// that loads the result once the output register is free.
// Reset (arst_n low, asynchronous) restores the key to its default, the hash to
// the FNV offset basis, the length count to zero, and empties the output.
module keyed_fnv1a_tag_checker #(
	parameter int MAX_BODY_BYTES = kftc_pkg::MAX_BODY_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [kftc_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte, [23:8] received_tag
	input  logic                            s_tlast,   // last_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [kftc_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] computed_tag, [16] tag_matches,
	                                                   // [17] length_ok, [23:18] zero
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kftc_pkg::HASH_W-1:0]     cfg_data
);
	import kftc_pkg::*;

	localparam int CNT_W = $clog2(MAX_BODY_BYTES + 1);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_BODY     = 5'b00010,
		ST_KEY_GO   = 5'b00100,
		ST_KEY_WAIT = 5'b01000,
		ST_FIN      = 5'b10000
	} state_t;

	state_t             state_q;
	logic [HASH_W-1:0]  secret_q;
	logic [HASH_W-1:0]  key_sh_q;
	logic [KCNT_W-1:0]  key_cnt_q;
	logic [CNT_W-1:0]   count_q;
	logic               last_q;
	logic [TAG_W-1:0]   rtag_q;
	logic               m_tvalid_q;
	logic [TAG_W-1:0]   tag_out_q;
	logic               match_out_q;
	logic               len_ok_out_q;

	kftc_cmd_t          cmd;
	kftc_sts_t          sts;
	logic [HASH_W-1:0]  hash;
	logic               accept;
	logic               fin_load;
	logic [TAG_W-1:0]   tag;
	logic               len_ok;

	kftc_hash_unit u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.hash   (hash)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign fin_load  = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	assign tag    = hash[HASH_W-1 -: TAG_W] ^ hash[TAG_W-1:0];
	assign len_ok = (count_q != CNT_W'(MAX_BODY_BYTES));

	always_comb begin
		cmd.start = accept || (state_q == ST_KEY_GO);
		cmd.clear = fin_load;
		cmd.din   = (state_q == ST_KEY_GO) ? key_sh_q[HASH_W-1 -: BYTE_W]
		                                   : s_tdata[BYTE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_q <= KEY_RESET;
		end else if (cfg_valid) begin
			secret_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			key_cnt_q <= '0;
			last_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						last_q  <= s_tlast;
						state_q <= ST_BODY;
						if (len_ok) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_BODY: begin
					if (sts.done) begin
						key_cnt_q <= '0;
						state_q   <= last_q ? ST_KEY_GO : ST_IDLE;
					end
				end
				ST_KEY_GO: begin
					state_q <= ST_KEY_WAIT;
				end
				ST_KEY_WAIT: begin
					if (sts.done) begin
						if (key_cnt_q == KCNT_W'(KEY_BYTES - 1)) begin
							state_q <= ST_FIN;
						end else begin
							key_cnt_q <= key_cnt_q + 1'b1;
							state_q   <= ST_KEY_GO;
						end
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rtag_q <= s_tdata[BYTE_W +: TAG_W];
		end
		if ((state_q == ST_BODY) && sts.done) begin
			key_sh_q <= secret_q;
		end else if (state_q == ST_KEY_GO) begin
			key_sh_q <= {key_sh_q[HASH_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			tag_out_q    <= tag;
			len_ok_out_q <= len_ok;
			match_out_q  <= len_ok && (tag == rtag_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - TAG_W - 2){1'b0}}, len_ok_out_q, match_out_q, tag_out_q};

endmodule

@@ hw/rtl/kftc_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the tag checker, bound to the top level.
module kftc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tlast,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [kftc_pkg::M_TDATA_W-1:0]  m_tdata
);
	import kftc_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a match implies the length was in range
	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[TAG_W] |-> m_tdata[TAG_W+1])
		else $error("tag match with bad length");

	// one item at a time: ready drops right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// a result never appears right after an accept of a non-last item
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
		else $error("result without a last item");

endmodule

bind keyed_fnv1a_tag_checker kftc_checker u_kftc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
